// ----- hw/rtl/e2q_pkg.sv -----
// e2q_pkg: constants, types and the CORDIC arctangent table for the
// Euler-to-quaternion unit. No dependencies.
package e2q_pkg;

  localparam int ANGLE_W      = 16;
  localparam int PHASE_W      = 33;
  localparam int CS_W         = 33;   // signed, 30 fraction bits, margin for gain
  localparam int ATAN_ENTRIES = 24;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_OUT_FRAC_BITS = 15;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032875;

  function automatic logic signed [PHASE_W-1:0] atan_turns(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// ----- hw/rtl/e2q_cordic_lane.sv -----
// e2q_cordic_lane: pipelined rotation-mode CORDIC, every stage registered,
// giving cos and sin of half the raw angle. Uses e2q_pkg.
module e2q_cordic_lane
  import e2q_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                      clk,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic signed [CS_W-1:0]    cos_q30,
  output logic signed [CS_W-1:0]    sin_q30
);
  localparam int N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // stage inputs (combinational) and stage registers
  logic signed [CS_W-1:0]    xin [N];
  logic signed [CS_W-1:0]    yin [N];
  logic signed [PHASE_W-1:0] pin [N];
  logic signed [CS_W-1:0]    xq  [N];
  logic signed [CS_W-1:0]    yq  [N];
  logic signed [PHASE_W-1:0] pq  [N];

  always_comb begin
    xin[0] = CORDIC_GAIN_Q30;
    yin[0] = '0;
    pin[0] = PHASE_W'(angle) <<< 15;
    for (int i = 1; i < N; i++) begin
      xin[i] = xq[i-1];
      yin[i] = yq[i-1];
      pin[i] = pq[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (pin[i] >= 0) begin
        xq[i] <= xin[i] - (yin[i] >>> i);
        yq[i] <= yin[i] + (xin[i] >>> i);
        pq[i] <= pin[i] - atan_turns(i);
      end else begin
        xq[i] <= xin[i] + (yin[i] >>> i);
        yq[i] <= yin[i] - (xin[i] >>> i);
        pq[i] <= pin[i] + atan_turns(i);
      end
    end
  end

  assign cos_q30 = xq[N-1];
  assign sin_q30 = yq[N-1];
endmodule

// ----- hw/rtl/e2q_merge.sv -----
// e2q_merge: combines the three lanes' cos/sin into w,x,y,z. Three register
// stages: pair products, products with g terms, sum/round/saturate. Uses e2q_pkg.
module e2q_merge
  import e2q_pkg::*;
#(
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic signed [CS_W-1:0]        ca, sa, cb, sb, cg, sg,
  output logic signed [OUT_FRAC_BITS:0] qw, qx, qy, qz
);
  localparam int PW = 66;
  localparam int SW = 68;

  logic signed [CS_W-1:0] cacb, sasb, sacb, casb, cg1, sg1;
  logic signed [PW-1:0]   p0, p1, p2, p3, p4, p5, p6, p7;

  function automatic logic signed [CS_W-1:0] mul30(input logic signed [CS_W-1:0] u,
                                                   input logic signed [CS_W-1:0] v);
    logic signed [PW-1:0] p;
    p = PW'(u) * PW'(v) + (PW'(1) <<< 29);
    return CS_W'(p >>> 30);
  endfunction

  function automatic logic signed [OUT_FRAC_BITS:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + (SW'(1) <<< (59 - OUT_FRAC_BITS))) >>> (60 - OUT_FRAC_BITS);
    if (r > (SW'(1) <<< OUT_FRAC_BITS) - 1) return {1'b0, {OUT_FRAC_BITS{1'b1}}};
    if (r < -(SW'(1) <<< OUT_FRAC_BITS))    return {1'b1, {OUT_FRAC_BITS{1'b0}}};
    return r[OUT_FRAC_BITS:0];
  endfunction

  always_ff @(posedge clk) begin
    cacb <= mul30(ca, cb);
    sasb <= mul30(sa, sb);
    sacb <= mul30(sa, cb);
    casb <= mul30(ca, sb);
    cg1  <= cg;
    sg1  <= sg;
    p0 <= PW'(cacb) * PW'(cg1);
    p1 <= PW'(sasb) * PW'(sg1);
    p2 <= PW'(sacb) * PW'(cg1);
    p3 <= PW'(casb) * PW'(sg1);
    p4 <= PW'(casb) * PW'(cg1);
    p5 <= PW'(sacb) * PW'(sg1);
    p6 <= PW'(cacb) * PW'(sg1);
    p7 <= PW'(sasb) * PW'(cg1);
    qw <= to_out(SW'(p0) + SW'(p1));
    qx <= to_out(SW'(p2) - SW'(p3));
    qy <= to_out(SW'(p4) + SW'(p5));
    qz <= to_out(SW'(p6) - SW'(p7));
  end
endmodule

// ----- hw/rtl/euler_to_quaternion_unit.sv -----
// Euler angles (ZYX) to unit quaternion, three CORDIC lanes and a merge stage.
// Throughput: one beat per cycle; busy is never raised, the pipeline is fully fed.
// Reset (rst, synchronous) clears the valid pipe only; data registers are not reset.
// The receiver cannot stall: done is a one-cycle strobe.
module euler_to_quaternion_unit
  import e2q_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_W-1:0]     roll_raw,
  input  logic signed [ANGLE_W-1:0]     pitch_raw,
  input  logic signed [ANGLE_W-1:0]     yaw_raw,
  output logic                          done,
  output logic signed [OUT_FRAC_BITS:0] quat_w,
  output logic signed [OUT_FRAC_BITS:0] quat_x,
  output logic signed [OUT_FRAC_BITS:0] quat_y,
  output logic signed [OUT_FRAC_BITS:0] quat_z
);
  localparam int N   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int LAT = N + 3;

  logic signed [CS_W-1:0] ca, sa, cb, sb, cg, sg;
  logic [LAT-1:0]         vpipe;

  assign busy = 1'b0;

  // one CORDIC lane per angle
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .angle(roll_raw), .cos_q30(ca), .sin_q30(sa));
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .angle(pitch_raw), .cos_q30(cb), .sin_q30(sb));
  e2q_cordic_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .angle(yaw_raw), .cos_q30(cg), .sin_q30(sg));

  e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk(clk), .ca(ca), .sa(sa), .cb(cb), .sb(sb), .cg(cg), .sg(sg),
    .qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z));

  // beat tracking alongside the data pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start & ~busy};
    end
  end

  assign done = vpipe[LAT-1];

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("missing result beat");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (vpipe == '0) |=> !done) else $error("spurious result beat");
`endif
endmodule

// ----- verif/euler_to_quaternion_unit_tb.sv -----
// Self-checking bench for euler_to_quaternion_unit: angle triples in, quaternion beats out.
// Depends on e2q_pkg and the unit itself; a bit-exact CORDIC predictor lives here.
module euler_to_quaternion_unit_tb;
  import e2q_pkg::*;

  localparam int STAGES    = DEF_CORDIC_STAGES;
  localparam int FRAC      = DEF_OUT_FRAC_BITS;
  localparam int LATENCY   = (STAGES > 24 ? 24 : STAGES) + 3;
  localparam int N_RANDOM  = 800;
  localparam int MAX_CYCLES = 200000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    logic                      drain;   // hold off until every quaternion is back
  } angles_t;

  typedef struct packed {
    logic signed [FRAC:0] w;
    logic signed [FRAC:0] x;
    logic signed [FRAC:0] y;
    logic signed [FRAC:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [ANGLE_W-1:0] roll_raw = '0, pitch_raw = '0, yaw_raw = '0;
  logic busy, done;
  logic signed [FRAC:0] quat_w, quat_x, quat_y, quat_z;

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      stimulus_done = 1'b0;

  always #5 clk = ~clk;

  euler_to_quaternion_unit DUT (
    .clk, .rst, .start, .busy, .roll_raw, .pitch_raw, .yaw_raw,
    .done, .quat_w, .quat_x, .quat_y, .quat_z
  );

  // --- predictor -------------------------------------------------------------
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;   // arithmetic on a signed longint, i.e. floor
  endfunction

  // Rotation-mode CORDIC on half the raw angle; cos/sin with 30 fraction bits.
  function automatic void half_cos_sin(input logic signed [ANGLE_W-1:0] raw,
                                       output longint c, output longint s);
    longint xs, ys, ph, dx, dy;
    xs = CORDIC_GAIN_Q30;
    ys = 0;
    ph = longint'(raw) * 32768;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = floor_shr(ys, i);
      dy = floor_shr(xs, i);
      if (ph >= 0) begin
        xs -= dx; ys += dy; ph -= longint'(atan_turns(i));
      end else begin
        xs += dx; ys -= dy; ph += longint'(atan_turns(i));
      end
    end
    c = xs;
    s = ys;
  endfunction

  function automatic longint mul_q30(longint u, longint v);
    return floor_shr(u * v + (64'sd1 <<< 29), 30);
  endfunction

  // 60 fraction bits down to the output word, round half up, saturate.
  function automatic logic signed [FRAC:0] round_sat(longint v60);
    longint r;
    r = floor_shr(v60 + (64'sd1 <<< (59 - FRAC)), 60 - FRAC);
    if (r > (64'sd1 <<< FRAC) - 1) r = (64'sd1 <<< FRAC) - 1;
    if (r < -(64'sd1 <<< FRAC)) r = -(64'sd1 <<< FRAC);
    return r[FRAC:0];
  endfunction

  function automatic quat_t predict_quat(angles_t a);
    longint ca, sa, cb, sb, cg, sg, cacb, sasb, sacb, casb;
    quat_t q;
    half_cos_sin(a.roll, ca, sa);
    half_cos_sin(a.pitch, cb, sb);
    half_cos_sin(a.yaw, cg, sg);
    cacb = mul_q30(ca, cb);
    sasb = mul_q30(sa, sb);
    sacb = mul_q30(sa, cb);
    casb = mul_q30(ca, sb);
    q.w = round_sat(cacb * cg + sasb * sg);
    q.x = round_sat(sacb * cg - casb * sg);
    q.y = round_sat(casb * cg + sacb * sg);
    q.z = round_sat(cacb * sg - sasb * cg);
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // --- stimulus ----------------------------------------------------------------
  function automatic angles_t make_angles(int r, int p, int y);
    angles_t a;
    a.roll = ANGLE_W'(r); a.pitch = ANGLE_W'(p); a.yaw = ANGLE_W'(y); a.drain = 1'b0;
    return a;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      1:       return ANGLE_W'($urandom_range(0, 15) - 8);              // near zero
      2:       return ANGLE_W'(32'h4000 + $urandom_range(0, 15) - 8);   // near +pi/2
      3:       return ANGLE_W'(32'hC000 + $urandom_range(0, 15) - 8);   // near -pi/2
      default: return ANGLE_W'($urandom());
    endcase
  endfunction

  task automatic queue_angles(angles_t a);
    pending_angles = {pending_angles, a};
  endtask

  initial begin
    angles_t a;
    int corner[5] = '{-32768, 32767, 0, 16384, -16384};
    // directed: extremes, minus pi, quarter turns, and saturation near +1
    foreach (corner[i]) queue_angles(make_angles(corner[i], 0, 0));
    foreach (corner[i]) queue_angles(make_angles(0, corner[i], 0));
    foreach (corner[i]) queue_angles(make_angles(0, 0, corner[i]));
    queue_angles(make_angles(-32768, -32768, -32768));
    queue_angles(make_angles(32767, 32767, 32767));
    queue_angles(make_angles(1, -1, 1));
    queue_angles(make_angles(16'h5555, 16'hAAAA, 16'h5555));
    a = make_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    a.drain = 1'b1;   // pause until every result has come
    queue_angles(a);
    for (int i = 0; i < N_RANDOM; i++) begin
      a.roll = rand_angle(); a.pitch = rand_angle(); a.yaw = rand_angle();
      a.drain = ($urandom_range(0, 199) == 0);
      queue_angles(a);
    end
    stimulus_done = 1'b1;
  end

  // --- reset and watchdog -------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("** euler_to_quaternion_unit: FAILED **");
      $finish;
    end
  end

  // --- driver: bursts and gaps, beat taken when start && !busy --------------------
  int  burst_left = 0;
  int  gap_left = 0;
  bit  draining = 1'b0;
  bit  all_sent = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // a beat presented last cycle is taken at this edge if busy was low
      if (start && !busy) begin
        expected_quats = {expected_quats, predict_quat(pending_angles[0])};
        if (pending_angles[0].drain) draining = 1'b1;
        void'(pending_angles.pop_front());
      end else if (start) begin
        // held: keep driving the same beat
      end
      if (draining && expected_quats.size() == 0) draining = 1'b0;
      if (!(start && busy)) begin
        if (gap_left > 0) gap_left--;
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
        if (pending_angles.size() != 0 && !draining && gap_left == 0 && burst_left > 0) begin
          burst_left--;
          start     <= 1'b1;
          roll_raw  <= pending_angles[0].roll;
          pitch_raw <= pending_angles[0].pitch;
          yaw_raw   <= pending_angles[0].yaw;
          if (burst_left == 0) gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end else begin
          start <= 1'b0;
        end
      end
      if (stimulus_done && pending_angles.size() == 0 && !(start && busy)) all_sent = 1'b1;
    end
  end

  // --- monitor: done is a one-cycle strobe, compare with oldest expectation ------
  always @(posedge clk) begin
    quat_t want;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected beat", quat_w, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
        if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
        if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
        if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
      end
    end
  end

  // --- end of run ---------------------------------------------------------------
  initial begin
    wait (all_sent);
    wait (expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0)
      $display("** euler_to_quaternion_unit: PASSED **");
    else
      $display("** euler_to_quaternion_unit: FAILED **");
    $finish;
  end

endmodule
